// ===== sv/jtss_pkg.sv =====
`timescale 1ns / 1ps
package jtss_pkg;

  // Joint count and the widths that follow from it
  localparam int NUM_JOINTS = 8;
  localparam int JIDX_W     = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int CNT_W      = $clog2(NUM_JOINTS + 1);

  // Field widths
  localparam int KIND_W  = 2;
  localparam int JOINT_W = 4;
  localparam int ANGLE_W = 24;
  localparam int SUM_W   = ANGLE_W + 1;
  localparam int GAIN_W  = 16;
  localparam int STEP_W  = 18;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = SUM_W + GAIN_W + 1;
  localparam int WORK_W  = SUM_W + 2;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_GAIN     = 2'd0;
  localparam logic [1:0] REG_MAX_STEP = 2'd1;
  localparam logic [1:0] REG_MIN_STEP = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET     = 16'd13107;
  localparam logic [STEP_W-1:0] MAX_STEP_RESET = 18'd16471;
  localparam logic [STEP_W-1:0] MIN_STEP_RESET = 18'd1647;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK = 2'd0,
    KIND_SET  = 2'd1,
    KIND_ADD  = 2'd2,
    KIND_LOAD = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CMD,
    B_TICK
  } back_state_t;

  // One queued word, already classified
  typedef struct packed {
    kind_t                     kind;
    logic [JOINT_W-1:0]        joint;
    logic                      joint_ok;
    logic signed [ANGLE_W-1:0] angle_value;
    logic signed [ANGLE_W-1:0] upper_bound;
  } item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [STEP_W-1:0] max_step;
    logic [STEP_W-1:0] min_step;
  } cfg_t;

endpackage

// ===== sv/jtss_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module jtss_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [jtss_pkg::KIND_W-1:0]       kind,
  input  wire logic [jtss_pkg::JOINT_W-1:0]      joint,
  input  wire logic signed [jtss_pkg::ANGLE_W-1:0] angle_value,
  input  wire logic signed [jtss_pkg::ANGLE_W-1:0] upper_bound,
  output jtss_pkg::item_t                        head,
  output logic                                   head_valid,
  input  wire logic                              pop
);

  jtss_pkg::item_t                    queue_mem [jtss_pkg::QUEUE_DEPTH];
  logic [jtss_pkg::QPTR_W-1:0]        wr_ptr;
  logic [jtss_pkg::QPTR_W-1:0]        rd_ptr;
  logic [jtss_pkg::QCNT_W-1:0]        count;
  logic                               push;
  jtss_pkg::item_t                    item_in;

  assign busy       = (count == jtss_pkg::QCNT_W'(jtss_pkg::QUEUE_DEPTH));
  assign push       = start && !busy;
  assign head_valid = (count != '0);
  assign head       = queue_mem[rd_ptr];

  // Classify the incoming word: kind decode and joint range check
  always_comb begin
    item_in.kind        = jtss_pkg::kind_t'(kind);
    item_in.joint       = joint;
    item_in.joint_ok    = ({1'b0, joint} < (jtss_pkg::JOINT_W + 1)'(jtss_pkg::NUM_JOINTS));
    item_in.angle_value = angle_value;
    item_in.upper_bound = upper_bound;
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= item_in;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == jtss_pkg::QPTR_W'(jtss_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == jtss_pkg::QPTR_W'(jtss_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  // Back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");
  // Fill count tracks push and pop
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= jtss_pkg::QCNT_W'(jtss_pkg::QUEUE_DEPTH))
    else $error("queue overfilled");
`endif

endmodule
`default_nettype wire

// ===== sv/jtss_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module jtss_back (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire jtss_pkg::cfg_t                     cfg,
  input  wire jtss_pkg::item_t                    head,
  input  wire logic                               head_valid,
  output logic                                    pop,
  output logic                                    strobe,
  output logic [jtss_pkg::JOINT_W-1:0]            joint_out,
  output logic signed [jtss_pkg::ANGLE_W-1:0]     angle_out,
  output logic                                    moving,
  output logic                                    ok,
  output logic                                    last
);

  localparam int AW = jtss_pkg::ANGLE_W;
  localparam int SW = jtss_pkg::SUM_W;
  localparam int WW = jtss_pkg::WORK_W;
  localparam int PW = jtss_pkg::PROD_W;
  localparam int JW = jtss_pkg::JIDX_W;
  localparam int CW = jtss_pkg::CNT_W;
  localparam int NJ = jtss_pkg::NUM_JOINTS;

  // Joint state
  logic signed [AW-1:0] target_angle  [NJ];
  logic signed [AW-1:0] current_angle [NJ];
  logic signed [AW-1:0] lower_limit   [NJ];
  logic signed [AW-1:0] upper_limit   [NJ];
  logic [NJ-1:0]        active_mask;

  jtss_pkg::back_state_t state, state_next;
  jtss_pkg::item_t       cur;

  // Tick pipeline: issue, multiply, update
  logic [CW-1:0]        iss;
  logic                 issue;
  logic [JW-1:0]        iss_idx;
  logic                 a_valid, b_valid;
  logic [JW-1:0]        a_idx, b_idx;
  logic                 a_act, b_act;
  logic signed [SW-1:0] a_dist, b_dist;
  logic signed [AW-1:0] a_cur, b_cur, a_tgt, b_tgt;
  logic signed [PW-1:0] b_prod;
  logic signed [PW-1:0] mul_a, mul_b;
  logic                 tick_done;

  // Update stage terms
  logic signed [WW-1:0] st_raw, d_w, mx_w, mn_w, abs_d, abs_s, st_sel, sum_w, rem_w, abs_r;
  logic signed [AW-1:0] upd_cur;
  logic                 upd_act;

  // Command stage terms
  logic [JW-1:0]        c_idx;
  logic signed [SW-1:0] c_val, c_up, c_lo;
  logic signed [AW-1:0] c_tgt;

  assign iss_idx   = iss[JW-1:0];
  assign issue     = (state == jtss_pkg::B_TICK) && (iss < CW'(NJ));
  assign tick_done = b_valid && (b_idx == JW'(NJ - 1));
  assign c_idx     = cur.joint[JW-1:0];

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jtss_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      jtss_pkg::B_IDLE: begin
        if (head_valid) begin
          pop        = 1'b1;
          state_next = (head.kind == jtss_pkg::KIND_TICK) ? jtss_pkg::B_TICK : jtss_pkg::B_CMD;
        end
      end
      jtss_pkg::B_CMD: begin
        state_next = jtss_pkg::B_IDLE;
      end
      jtss_pkg::B_TICK: begin
        if (tick_done) begin
          state_next = jtss_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = jtss_pkg::B_IDLE;
      end
    endcase
  end

  // Word latch and issue counter
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss     <= '0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (pop) begin
        iss <= '0;
      end else if (issue) begin
        iss <= iss + 1'b1;
      end
      a_valid <= issue;
      b_valid <= a_valid;
    end
  end

  // Issue stage: read joint, form distance
  always_ff @(posedge clk) begin
    if (issue) begin
      a_idx  <= iss_idx;
      a_act  <= active_mask[iss_idx];
      a_cur  <= current_angle[iss_idx];
      a_tgt  <= target_angle[iss_idx];
      a_dist <= SW'(target_angle[iss_idx]) - SW'(current_angle[iss_idx]);
    end
  end

  // Multiply stage: distance times gain
  assign mul_a = PW'(a_dist);
  assign mul_b = PW'($signed({1'b0, cfg.gain}));

  always_ff @(posedge clk) begin
    if (a_valid) begin
      b_idx  <= a_idx;
      b_act  <= a_act;
      b_cur  <= a_cur;
      b_tgt  <= a_tgt;
      b_dist <= a_dist;
      b_prod <= mul_a * mul_b;
    end
  end

  // Update stage: floor, limit, raise or snap, then done check
  always_comb begin
    st_raw = WW'(b_prod >>> jtss_pkg::FRAC_W);
    d_w    = WW'(b_dist);
    mx_w   = WW'($signed({1'b0, cfg.max_step}));
    mn_w   = WW'($signed({1'b0, cfg.min_step}));
    abs_d  = (d_w < 0) ? -d_w : d_w;
    abs_s  = (st_raw < 0) ? -st_raw : st_raw;
    if (st_raw > mx_w) begin
      st_sel = mx_w;
    end else if (st_raw < -mx_w) begin
      st_sel = -mx_w;
    end else if ((abs_s < mn_w) && (abs_d > mn_w)) begin
      st_sel = (d_w > 0) ? mn_w : -mn_w;
    end else if (abs_d <= mn_w) begin
      st_sel = d_w;
    end else begin
      st_sel = st_raw;
    end
    sum_w   = WW'(b_cur) + st_sel;
    upd_cur = b_act ? sum_w[AW-1:0] : b_cur;
    rem_w   = WW'(b_tgt) - WW'(upd_cur);
    abs_r   = (rem_w < 0) ? -rem_w : rem_w;
    upd_act = b_act && (abs_r > mn_w);
  end

  // Set and add: clamp into limits, upper first
  always_comb begin
    c_up = SW'(upper_limit[c_idx]);
    c_lo = SW'(lower_limit[c_idx]);
    if (cur.kind == jtss_pkg::KIND_ADD) begin
      c_val = SW'(target_angle[c_idx]) + SW'(cur.angle_value);
    end else begin
      c_val = SW'(cur.angle_value);
    end
    if (c_val > c_up) begin
      c_tgt = c_up[AW-1:0];
    end else if (c_val < c_lo) begin
      c_tgt = c_lo[AW-1:0];
    end else begin
      c_tgt = c_val[AW-1:0];
    end
  end

  // Joint state writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NJ; i++) begin
        target_angle[i]  <= '0;
        current_angle[i] <= '0;
        lower_limit[i]   <= '0;
        upper_limit[i]   <= '0;
      end
      active_mask <= '0;
    end else begin
      if (b_valid) begin
        current_angle[b_idx] <= upd_cur;
        active_mask[b_idx]   <= upd_act;
      end
      if ((state == jtss_pkg::B_CMD) && cur.joint_ok) begin
        case (cur.kind)
          jtss_pkg::KIND_SET, jtss_pkg::KIND_ADD: begin
            target_angle[c_idx] <= c_tgt;
            active_mask[c_idx]  <= 1'b1;
          end
          jtss_pkg::KIND_LOAD: begin
            lower_limit[c_idx] <= cur.angle_value;
            upper_limit[c_idx] <= cur.upper_bound;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= b_valid || (state == jtss_pkg::B_CMD);
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      joint_out <= jtss_pkg::JOINT_W'(b_idx);
      angle_out <= upd_cur;
      moving    <= upd_act;
      ok        <= 1'b1;
      last      <= tick_done;
    end else if (state == jtss_pkg::B_CMD) begin
      joint_out <= cur.joint;
      ok        <= cur.joint_ok;
      last      <= 1'b1;
      if (!cur.joint_ok) begin
        angle_out <= '0;
        moving    <= 1'b0;
      end else if (cur.kind == jtss_pkg::KIND_LOAD) begin
        angle_out <= target_angle[c_idx];
        moving    <= active_mask[c_idx];
      end else begin
        angle_out <= c_tgt;
        moving    <= 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  // Final word of an item leaves the back end idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> state == jtss_pkg::B_IDLE)
    else $error("last word while back end still busy");
  // A tick reports its joints on consecutive cycles
  a_tick_burst: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("gap inside tick burst");
  // A rejected joint reports nothing but its index
  a_bad_joint: assert property (@(posedge clk) disable iff (rst)
    (strobe && !ok) |-> (!moving && angle_out == '0 && last))
    else $error("bad joint word carries data");
  // Pipeline never updates a joint beyond the last
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (CW'(b_idx) < CW'(NJ)))
    else $error("tick index out of range");
`endif

endmodule
`default_nettype wire

// ===== sv/joint_target_servo_stepper_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake                      Payload
// command   start in, busy out            kind, joint, angle_value, upper_bound
// result    strobe out, one per word       joint_out, angle_out, moving, ok, last
// config    psel/penable/pwrite, pready=1 paddr, pwdata, prdata
//
// Set, add and load: the word passes the queue, the back end's idle and command
// states and the result register. Tick: one result word per cycle, from the shared
// issue/multiply/update pipeline walking the joints, after the queue.
// A two-word queue parts front and back; busy is high only while it is full.
// Synchronous reset clears all joint state and the registers to their defaults.
// The receiver cannot stall; each result word is shown for exactly one cycle.
module joint_target_servo_stepper_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [jtss_pkg::KIND_W-1:0]         kind,
  input  wire logic [jtss_pkg::JOINT_W-1:0]        joint,
  input  wire logic signed [jtss_pkg::ANGLE_W-1:0] angle_value,
  input  wire logic signed [jtss_pkg::ANGLE_W-1:0] upper_bound,
  output logic                                     strobe,
  output logic [jtss_pkg::JOINT_W-1:0]             joint_out,
  output logic signed [jtss_pkg::ANGLE_W-1:0]      angle_out,
  output logic                                     moving,
  output logic                                     ok,
  output logic                                     last,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [jtss_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [jtss_pkg::DATA_W-1:0]         pwdata,
  output logic [jtss_pkg::DATA_W-1:0]              prdata,
  output logic                                     pready
);

  jtss_pkg::cfg_t  cfg;
  jtss_pkg::item_t head;
  logic            head_valid;
  logic            pop;
  logic            wr_en;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain     <= jtss_pkg::GAIN_RESET;
      cfg.max_step <= jtss_pkg::MAX_STEP_RESET;
      cfg.min_step <= jtss_pkg::MIN_STEP_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        jtss_pkg::REG_GAIN:     cfg.gain     <= pwdata[jtss_pkg::GAIN_W-1:0];
        jtss_pkg::REG_MAX_STEP: cfg.max_step <= pwdata[jtss_pkg::STEP_W-1:0];
        jtss_pkg::REG_MIN_STEP: cfg.min_step <= pwdata[jtss_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      jtss_pkg::REG_GAIN:     prdata = jtss_pkg::DATA_W'(cfg.gain);
      jtss_pkg::REG_MAX_STEP: prdata = jtss_pkg::DATA_W'(cfg.max_step);
      jtss_pkg::REG_MIN_STEP: prdata = jtss_pkg::DATA_W'(cfg.min_step);
      default:                prdata = '0;
    endcase
  end

  jtss_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .joint       (joint),
    .angle_value (angle_value),
    .upper_bound (upper_bound),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop)
  );

  jtss_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .strobe     (strobe),
    .joint_out  (joint_out),
    .angle_out  (angle_out),
    .moving     (moving),
    .ok         (ok),
    .last       (last)
  );

endmodule
`default_nettype wire
